@@ design/sfic_pkg.sv @@
`timescale 1ns / 1ps

package sfic_pkg;

    // Number of conversion lanes and register stages per lane.
    localparam int LANES  = 4;
    localparam int STAGES = 5;

    // Operand and result formats of one lane.
    localparam logic [1:0] FMT_INT32 = 2'd0;
    localparam logic [1:0] FMT_INT64 = 2'd1;
    localparam logic [1:0] FMT_SGL   = 2'd2;
    localparam logic [1:0] FMT_DBL   = 2'd3;

    // Rounding modes, in the encoding of the rounding mode register.
    localparam logic [1:0] RM_NEAR  = 2'd0;
    localparam logic [1:0] RM_DOWN  = 2'd1;
    localparam logic [1:0] RM_UP    = 2'd2;
    localparam logic [1:0] RM_TRUNC = 2'd3;

    // How lane results are placed in the destination.
    localparam logic [1:0] PACK_W64   = 2'd0;
    localparam logic [1:0] PACK_N32X2 = 2'd1;
    localparam logic [1:0] PACK_N32X4 = 2'd2;

    // Destination register files.
    localparam logic [1:0] KIND_XMM = 2'd0;
    localparam logic [1:0] KIND_MMX = 2'd1;
    localparam logic [1:0] KIND_GPR = 2'd2;

    // Byte counts written to the destination.
    localparam logic [4:0] BYTES_NONE = 5'd0;
    localparam logic [4:0] BYTES_4    = 5'd4;
    localparam logic [4:0] BYTES_8    = 5'd8;
    localparam logic [4:0] BYTES_16   = 5'd16;

    localparam logic [63:0] LANE_MASK = 64'h0000_0000_ffff_ffff;

    typedef struct packed {
        logic [1:0] src_fmt;
        logic [1:0] dst_fmt;
        logic [1:0] rmode;
    } lane_op_t;

    typedef struct packed {
        logic [1:0] pack;
        logic [4:0] bytes;
        logic [1:0] kind;
        logic       bad;
    } ctx_t;

endpackage

@@ design/sfic_lane.sv @@
`timescale 1ns / 1ps

module sfic_lane
    import sfic_pkg::*;
(
    input  logic              clk,
    input  logic [STAGES-1:0] en,
    input  lane_op_t          op,
    input  logic [63:0]       opnd,
    output logic [63:0]       res
);

    // Leading zero count of a 64-bit word, 64 when the word is zero.
    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [7:0] nz;
        logic [2:0] blz [8];
        logic [7:0] by;
        logic [6:0] r;
        for (int b = 0; b < 8; b++) begin
            by     = x[8*b +: 8];
            nz[b]  = |by;
            blz[b] = 3'd0;
            for (int i = 0; i < 8; i++) begin
                if (by[i]) begin
                    blz[b] = 3'(7 - i);
                end
            end
        end
        r = 7'd64;
        for (int b = 0; b < 8; b++) begin
            if (nz[b]) begin
                r = {1'b0, 3'(7 - b), blz[b]};
            end
        end
        return r;
    endfunction

    // Stage A: unpack into sign, magnitude and exponent.
    logic               a_sign_next, a_sign_reg;
    logic [63:0]        a_mag_next, a_mag_reg;
    logic signed [12:0] a_ex_next, a_ex_reg;
    logic               a_spec_next, a_spec_reg;
    logic               a_nan_next, a_nan_reg;
    logic [51:0]        a_frac_next, a_frac_reg;
    lane_op_t           a_op_reg;
    logic [63:0]        se;
    logic [7:0]         e8;
    logic [10:0]        e11;

    always_comb
    begin
        a_sign_next = 1'b0;
        a_mag_next  = 64'd0;
        a_ex_next   = 13'sd0;
        a_spec_next = 1'b0;
        a_nan_next  = 1'b0;
        a_frac_next = 52'd0;
        se          = opnd;
        e8          = opnd[30:23];
        e11         = opnd[62:52];
        case (op.src_fmt)
            FMT_INT32:
            begin
                se          = {{32{opnd[31]}}, opnd[31:0]};
                a_sign_next = opnd[31];
                a_mag_next  = a_sign_next ? (~se + 64'd1) : se;
            end
            FMT_INT64:
            begin
                a_sign_next = opnd[63];
                a_mag_next  = a_sign_next ? (~se + 64'd1) : se;
            end
            FMT_SGL:
            begin
                a_sign_next = opnd[31];
                a_spec_next = (e8 == 8'hff);
                a_nan_next  = a_spec_next && (opnd[22:0] != 23'd0);
                a_frac_next = {opnd[22:0], 29'd0};
                a_mag_next  = {40'd0, (e8 != 8'd0), opnd[22:0]};
                a_ex_next   = (e8 == 8'd0) ? -13'sd149
                                           : $signed({5'd0, e8}) - 13'sd150;
            end
            default:
            begin
                a_sign_next = opnd[63];
                a_spec_next = (e11 == 11'h7ff);
                a_nan_next  = a_spec_next && (opnd[51:0] != 52'd0);
                a_frac_next = opnd[51:0];
                a_mag_next  = {11'd0, (e11 != 11'd0), opnd[51:0]};
                a_ex_next   = (e11 == 11'd0) ? -13'sd1074
                                             : $signed({2'd0, e11}) - 13'sd1075;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_sign_reg <= a_sign_next;
            a_mag_reg  <= a_mag_next;
            a_ex_reg   <= a_ex_next;
            a_spec_reg <= a_spec_next;
            a_nan_reg  <= a_nan_next;
            a_frac_reg <= a_frac_next;
            a_op_reg   <= op;
        end
    end

    // Stage B: count leading zeros.
    logic               b_sign_reg, b_spec_reg, b_nan_reg;
    logic [63:0]        b_mag_reg;
    logic signed [12:0] b_ex_reg;
    logic [51:0]        b_frac_reg;
    lane_op_t           b_op_reg;
    logic [6:0]         b_lz_next, b_lz_reg;

    assign b_lz_next = lzc64(a_mag_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_sign_reg <= a_sign_reg;
            b_mag_reg  <= a_mag_reg;
            b_ex_reg   <= a_ex_reg;
            b_spec_reg <= a_spec_reg;
            b_nan_reg  <= a_nan_reg;
            b_frac_reg <= a_frac_reg;
            b_op_reg   <= a_op_reg;
            b_lz_reg   <= b_lz_next;
        end
    end

    // Stage C: normalize so that the leading one sits at bit 63.
    logic               c_sign_reg, c_spec_reg, c_nan_reg, c_zero_reg;
    logic [63:0]        c_norm_next, c_norm_reg;
    logic signed [12:0] c_u_next, c_u_reg;
    logic [51:0]        c_frac_reg;
    lane_op_t           c_op_reg;

    assign c_norm_next = b_mag_reg << b_lz_reg[5:0];
    assign c_u_next    = b_ex_reg + 13'sd63 - $signed({6'd0, b_lz_reg});

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c_sign_reg <= b_sign_reg;
            c_spec_reg <= b_spec_reg;
            c_nan_reg  <= b_nan_reg;
            c_zero_reg <= b_lz_reg[6];
            c_norm_reg <= c_norm_next;
            c_u_reg    <= c_u_next;
            c_frac_reg <= b_frac_reg;
            c_op_reg   <= b_op_reg;
        end
    end

    // Stage D: align to the rounding point, collect guard and sticky bits.
    logic               d_is_int;
    logic signed [12:0] d_emin, d_bias, d_base, d_sraw, d_eb;
    logic               d_sub, d_sat;
    logic [6:0]         d_samt;
    logic [127:0]       d_wide;
    logic [63:0]        d_ip_next, d_ip_reg;
    logic               d_g_next, d_g_reg, d_st_next, d_st_reg;
    logic               d_ovf_next, d_ovf_reg;
    logic [11:0]        d_ebm1_next, d_ebm1_reg;
    logic               d_sign_reg, d_spec_reg, d_nan_reg, d_zero_reg;
    logic [51:0]        d_frac_reg;
    lane_op_t           d_op_reg;

    always_comb
    begin
        d_is_int = (c_op_reg.dst_fmt == FMT_INT32) || (c_op_reg.dst_fmt == FMT_INT64);
        if (c_op_reg.dst_fmt == FMT_SGL)
        begin
            d_emin = -13'sd126;
            d_bias = 13'sd127;
            d_base = 13'sd40;
        end
        else
        begin
            d_emin = -13'sd1022;
            d_bias = 13'sd1023;
            d_base = 13'sd11;
        end
        d_sub = c_u_reg < d_emin;
        d_eb  = c_u_reg + d_bias;
        if (d_is_int)
        begin
            d_ovf_next = c_u_reg > 13'sd63;
            d_sraw     = 13'sd63 - c_u_reg;
        end
        else
        begin
            d_ovf_next = 1'b0;
            d_sraw     = d_sub ? (d_base + d_emin - c_u_reg) : d_base;
        end
        d_sat  = d_sraw > 13'sd64;
        d_samt = d_sat ? 7'd64 : d_sraw[6:0];
        d_wide = {c_norm_reg, 64'd0} >> d_samt;
        if (d_sat)
        begin
            d_ip_next = 64'd0;
            d_g_next  = 1'b0;
            d_st_next = !c_zero_reg;
        end
        else
        begin
            d_ip_next = d_wide[127:64];
            d_g_next  = d_wide[63];
            d_st_next = |d_wide[62:0];
        end
        d_ebm1_next = d_sub ? 12'd0 : 12'(d_eb - 13'sd1);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            d_ip_reg   <= d_ip_next;
            d_g_reg    <= d_g_next;
            d_st_reg   <= d_st_next;
            d_ovf_reg  <= d_ovf_next;
            d_ebm1_reg <= d_ebm1_next;
            d_sign_reg <= c_sign_reg;
            d_spec_reg <= c_spec_reg;
            d_nan_reg  <= c_nan_reg;
            d_zero_reg <= c_zero_reg;
            d_frac_reg <= c_frac_reg;
            d_op_reg   <= c_op_reg;
        end
    end

    // Stage E: round, range check and pack.
    logic        e_inc;
    logic [64:0] e_m, e_lim, e_sum;
    logic [63:0] e_neg, e_ival, e_indef, e_fval, res_next, res_reg;
    logic        e_ibad, e_finf;

    always_comb
    begin
        case (d_op_reg.rmode)
            RM_NEAR:  e_inc = d_g_reg && (d_st_reg || d_ip_reg[0]);
            RM_DOWN:  e_inc = d_sign_reg && (d_g_reg || d_st_reg);
            RM_UP:    e_inc = !d_sign_reg && (d_g_reg || d_st_reg);
            default:  e_inc = 1'b0;
        endcase
        e_m = {1'b0, d_ip_reg} + {64'd0, e_inc};

        // Integer destination.
        if (d_op_reg.dst_fmt == FMT_INT64)
        begin
            e_lim   = d_sign_reg ? 65'h0_8000_0000_0000_0000 : 65'h0_7fff_ffff_ffff_ffff;
            e_indef = 64'h8000_0000_0000_0000;
        end
        else
        begin
            e_lim   = d_sign_reg ? 65'h0_0000_0000_8000_0000 : 65'h0_0000_0000_7fff_ffff;
            e_indef = 64'h0000_0000_8000_0000;
        end
        e_ibad = d_spec_reg || d_ovf_reg || (e_m > e_lim);
        e_neg  = ~e_m[63:0] + 64'd1;
        e_ival = d_sign_reg ? e_neg : e_m[63:0];
        if (d_op_reg.dst_fmt == FMT_INT32)
        begin
            e_ival = e_ival & LANE_MASK;
        end

        // Floating-point destination: biased exponent minus one, plus the
        // significand with its leading one, carries into the exponent.
        if (d_op_reg.dst_fmt == FMT_SGL)
        begin
            e_sum  = ({53'd0, d_ebm1_reg} << 23) + e_m;
            e_finf = e_sum >= 65'h0_0000_0000_7f80_0000;
            if (d_spec_reg)
            begin
                e_fval = d_nan_reg
                    ? {32'd0, d_sign_reg, 8'hff, 1'b1, d_frac_reg[50:29]}
                    : {32'd0, d_sign_reg, 8'hff, 23'd0};
            end
            else if (d_zero_reg)
            begin
                e_fval = {32'd0, d_sign_reg, 31'd0};
            end
            else if (e_finf)
            begin
                e_fval = {32'd0, d_sign_reg, 8'hff, 23'd0};
            end
            else
            begin
                e_fval = {32'd0, d_sign_reg, e_sum[30:0]};
            end
        end
        else
        begin
            e_sum  = ({53'd0, d_ebm1_reg} << 52) + e_m;
            e_finf = e_sum >= 65'h0_7ff0_0000_0000_0000;
            if (d_spec_reg)
            begin
                e_fval = d_nan_reg ? {d_sign_reg, 11'h7ff, 1'b1, d_frac_reg[50:0]}
                                   : {d_sign_reg, 11'h7ff, 52'd0};
            end
            else if (d_zero_reg)
            begin
                e_fval = {d_sign_reg, 63'd0};
            end
            else if (e_finf)
            begin
                e_fval = {d_sign_reg, 11'h7ff, 52'd0};
            end
            else
            begin
                e_fval = {d_sign_reg, e_sum[62:0]};
            end
        end

        if ((d_op_reg.dst_fmt == FMT_INT32) || (d_op_reg.dst_fmt == FMT_INT64))
        begin
            res_next = e_ibad ? e_indef : e_ival;
        end
        else
        begin
            res_next = e_fval;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

@@ design/sse_float_int_converter.sv @@
`timescale 1ns / 1ps

// SSE/SSE2 conversion unit. Each input beat carries one decoded conversion
// instruction (opcode group and prefix in action, REX.W in wide_int, and a
// 128-bit source) and produces exactly one output beat with the converted
// bits, the number of destination bytes written, the destination register
// file and an illegal flag for undefined opcode and prefix pairs. Four
// identical lanes run a five-stage pipeline (unpack, leading-zero count,
// normalize, align with guard and sticky bits, round and pack), so a new
// beat can enter every cycle when the output side keeps ready high. Every
// stage holds its own valid bit, so a stall at the output fills bubbles
// before it pushes back on in_ready. The rounding mode register is sampled
// when a beat is accepted; write it through cfg_write and cfg_data only
// while the unit is empty. Float-to-integer forms round by that mode, the
// truncating forms always truncate, and every conversion to floating point
// rounds to nearest even.
module sse_float_int_converter
    import sfic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  action,
    input  logic        wide_int,
    input  logic [63:0] src_low,
    input  logic [63:0] src_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] dst_low,
    output logic [63:0] dst_high,
    output logic [4:0]  write_bytes,
    output logic [1:0]  dest_kind,
    output logic        illegal
);

    // Action codes: opcode group times four plus prefix.
    localparam logic [4:0] ACT_CVTPI2PS  = 5'd0;
    localparam logic [4:0] ACT_CVTPI2PD  = 5'd1;
    localparam logic [4:0] ACT_CVTSI2SD  = 5'd2;
    localparam logic [4:0] ACT_CVTSI2SS  = 5'd3;
    localparam logic [4:0] ACT_CVTTPS2PI = 5'd4;
    localparam logic [4:0] ACT_CVTTPD2PI = 5'd5;
    localparam logic [4:0] ACT_CVTTSD2SI = 5'd6;
    localparam logic [4:0] ACT_CVTTSS2SI = 5'd7;
    localparam logic [4:0] ACT_CVTPS2PI  = 5'd8;
    localparam logic [4:0] ACT_CVTPD2PI  = 5'd9;
    localparam logic [4:0] ACT_CVTSD2SI  = 5'd10;
    localparam logic [4:0] ACT_CVTSS2SI  = 5'd11;
    localparam logic [4:0] ACT_CVTPS2PD  = 5'd12;
    localparam logic [4:0] ACT_CVTPD2PS  = 5'd13;
    localparam logic [4:0] ACT_CVTSD2SS  = 5'd14;
    localparam logic [4:0] ACT_CVTSS2SD  = 5'd15;
    localparam logic [4:0] ACT_CVTDQ2PS  = 5'd16;
    localparam logic [4:0] ACT_CVTPS2DQ  = 5'd17;
    localparam logic [4:0] ACT_CVTTPS2DQ = 5'd19;
    localparam logic [4:0] ACT_CVTTPD2DQ = 5'd21;
    localparam logic [4:0] ACT_CVTPD2DQ  = 5'd22;
    localparam logic [4:0] ACT_CVTDQ2PD  = 5'd23;

    logic [1:0] rounding_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounding_mode_reg <= RM_NEAR;
        end
        else if (cfg_write)
        begin
            rounding_mode_reg <= cfg_data;
        end
    end

    // Stage handshake: a stage loads when it is empty or its content moves on.
    logic [STAGES-1:0] valid_reg, valid_next, en;

    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];

    // Instruction decode.
    lane_op_t   op;
    ctx_t       ctx;
    logic       lane64;
    logic [1:0] int_fmt;
    logic [1:0] rc;

    always_comb
    begin
        int_fmt   = wide_int ? FMT_INT64 : FMT_INT32;
        rc        = rounding_mode_reg;
        op        = '{src_fmt: FMT_INT32, dst_fmt: FMT_SGL, rmode: RM_NEAR};
        lane64    = 1'b0;
        ctx       = '{pack: PACK_W64, bytes: BYTES_16, kind: KIND_XMM, bad: 1'b0};
        unique case (action)
            ACT_CVTPI2PS:
            begin
                ctx.pack  = PACK_N32X2;
                ctx.bytes = BYTES_8;
            end
            ACT_CVTPI2PD, ACT_CVTDQ2PD:
            begin
                op.dst_fmt = FMT_DBL;
            end
            ACT_CVTSI2SD:
            begin
                op.src_fmt = int_fmt;
                op.dst_fmt = FMT_DBL;
                ctx.bytes  = BYTES_8;
            end
            ACT_CVTSI2SS:
            begin
                op.src_fmt = int_fmt;
                ctx.pack   = PACK_N32X2;
                ctx.bytes  = BYTES_4;
            end
            ACT_CVTTPS2PI, ACT_CVTPS2PI:
            begin
                op = '{src_fmt: FMT_SGL, dst_fmt: FMT_INT32,
                       rmode: (action == ACT_CVTTPS2PI) ? RM_TRUNC : rc};
                ctx.pack  = PACK_N32X2;
                ctx.bytes = BYTES_8;
                ctx.kind  = KIND_MMX;
            end
            ACT_CVTTPD2PI, ACT_CVTPD2PI:
            begin
                op = '{src_fmt: FMT_DBL, dst_fmt: FMT_INT32,
                       rmode: (action == ACT_CVTTPD2PI) ? RM_TRUNC : rc};
                lane64    = 1'b1;
                ctx.pack  = PACK_N32X2;
                ctx.bytes = BYTES_8;
                ctx.kind  = KIND_MMX;
            end
            ACT_CVTTSD2SI, ACT_CVTSD2SI:
            begin
                op = '{src_fmt: FMT_DBL, dst_fmt: int_fmt,
                       rmode: (action == ACT_CVTTSD2SI) ? RM_TRUNC : rc};
                ctx.bytes = BYTES_8;
                ctx.kind  = KIND_GPR;
            end
            ACT_CVTTSS2SI, ACT_CVTSS2SI:
            begin
                op = '{src_fmt: FMT_SGL, dst_fmt: int_fmt,
                       rmode: (action == ACT_CVTTSS2SI) ? RM_TRUNC : rc};
                ctx.bytes = BYTES_8;
                ctx.kind  = KIND_GPR;
            end
            ACT_CVTPS2PD:
            begin
                op = '{src_fmt: FMT_SGL, dst_fmt: FMT_DBL, rmode: RM_NEAR};
            end
            ACT_CVTPD2PS:
            begin
                op = '{src_fmt: FMT_DBL, dst_fmt: FMT_SGL, rmode: RM_NEAR};
                lane64   = 1'b1;
                ctx.pack = PACK_N32X2;
            end
            ACT_CVTSD2SS:
            begin
                op = '{src_fmt: FMT_DBL, dst_fmt: FMT_SGL, rmode: RM_NEAR};
                ctx.pack  = PACK_N32X2;
                ctx.bytes = BYTES_4;
            end
            ACT_CVTSS2SD:
            begin
                op = '{src_fmt: FMT_SGL, dst_fmt: FMT_DBL, rmode: RM_NEAR};
                ctx.bytes = BYTES_8;
            end
            ACT_CVTDQ2PS:
            begin
                ctx.pack = PACK_N32X4;
            end
            ACT_CVTPS2DQ, ACT_CVTTPS2DQ:
            begin
                op = '{src_fmt: FMT_SGL, dst_fmt: FMT_INT32,
                       rmode: (action == ACT_CVTTPS2DQ) ? RM_TRUNC : rc};
                ctx.pack = PACK_N32X4;
            end
            ACT_CVTTPD2DQ, ACT_CVTPD2DQ:
            begin
                op = '{src_fmt: FMT_DBL, dst_fmt: FMT_INT32,
                       rmode: (action == ACT_CVTTPD2DQ) ? RM_TRUNC : rc};
                lane64   = 1'b1;
                ctx.pack = PACK_N32X2;
            end
            default:
            begin
                ctx = '{pack: PACK_W64, bytes: BYTES_NONE, kind: KIND_XMM, bad: 1'b1};
            end
        endcase
    end

    // Lane operands: four 32-bit elements, or two 64-bit elements.
    logic [63:0] opnd [LANES];
    logic [63:0] lane_res [LANES];

    assign opnd[0] = src_low;
    assign opnd[1] = lane64 ? src_high : {32'd0, src_low[63:32]};
    assign opnd[2] = {32'd0, src_high[31:0]};
    assign opnd[3] = {32'd0, src_high[63:32]};

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        sfic_lane u_lane (
            .clk  (clk),
            .en   (en),
            .op   (op),
            .opnd (opnd[i]),
            .res  (lane_res[i])
        );
    end

    // Destination placement travels alongside the lanes.
    ctx_t ctx_reg [STAGES];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ctx_reg[0] <= ctx;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k])
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    // Assemble the result from the final lane registers; bytes beyond the
    // written width read as zero.
    ctx_t        out_ctx;
    logic [63:0] lo, hi;

    always_comb
    begin
        out_ctx = ctx_reg[STAGES-1];
        case (out_ctx.pack)
            PACK_N32X2:
            begin
                lo = {lane_res[1][31:0], lane_res[0][31:0]};
                hi = 64'd0;
            end
            PACK_N32X4:
            begin
                lo = {lane_res[1][31:0], lane_res[0][31:0]};
                hi = {lane_res[3][31:0], lane_res[2][31:0]};
            end
            default:
            begin
                lo = lane_res[0];
                hi = lane_res[1];
            end
        endcase
        if (out_ctx.bytes != BYTES_16)
        begin
            hi = 64'd0;
        end
        if (out_ctx.bytes == BYTES_4)
        begin
            lo = lo & LANE_MASK;
        end
        if (out_ctx.bad)
        begin
            lo = 64'd0;
        end
    end

    assign dst_low     = lo;
    assign dst_high    = hi;
    assign write_bytes = out_ctx.bytes;
    assign dest_kind   = out_ctx.kind;
    assign illegal     = out_ctx.bad;

endmodule
